// ===== sv/cce_pkg.sv =====
// Shared types and constants of the connected component enumerator.
package cce_pkg;

  localparam int NODE_W   = 6;
  localparam int NCOUNT_W = 7;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_CLR_ALL = 2'd1,
    OP_CLR_VIS = 2'd2,
    OP_NEXT    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NONE  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_WALK,
    S_FINAL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    app_write;
    logic    clr_all;
    logic    clr_vis;
    logic    scan_rst;
    logic    scan_inc;
    logic    root_start;
    logic    push;
    logic    pop;
    logic    cur_inc;
    logic    set_status;
    status_t status;
    logic    emit_single;
    logic    emit_pend;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic range_ok;
    logic list_full;
    logic scan_end;
    logic scan_unvis;
    logic exhausted;
    logic depth_one;
    logic child_ok;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/cce_ctrl.sv =====
// Controller state machine sequencing operations and the depth-first walk.
module cce_ctrl
  import cce_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.op)
          OP_APPEND: begin
            cmd.set_status = 1'b1;
            if (!st.range_ok) begin
              cmd.status = ST_RANGE;
            end else if (st.list_full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.status    = ST_OK;
              cmd.app_write = 1'b1;
            end
            state_next = S_EMIT;
          end
          OP_CLR_ALL: begin
            cmd.clr_all    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_next     = S_EMIT;
          end
          OP_CLR_VIS: begin
            cmd.clr_vis    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_next     = S_EMIT;
          end
          OP_NEXT: begin
            cmd.scan_rst = 1'b1;
            state_next   = S_SCAN;
          end
          default: begin
            state_next = S_EMIT;
          end
        endcase
      end
      S_SCAN: begin
        if (st.scan_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NONE;
          state_next     = S_EMIT;
        end else if (st.scan_unvis) begin
          cmd.root_start = 1'b1;
          state_next     = S_WALK;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_WALK: begin
        if (st.exhausted) begin
          cmd.pop = 1'b1;
          if (st.depth_one) begin
            state_next = S_FINAL;
          end
        end else if (st.child_ok) begin
          if (st.out_free) begin
            cmd.push      = 1'b1;
            cmd.emit_pend = 1'b1;
          end
        end else begin
          cmd.cur_inc = 1'b1;
        end
      end
      S_FINAL: begin
        if (st.out_free) begin
          cmd.emit_pend = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/cce_dp.sv =====
// Datapath: graph memories, visited map, walk stack and output register.
module cce_dp
  import cce_pkg::*;
#(
  parameter int MAX_NODES  = 64,
  parameter int MAX_DEGREE = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [NCOUNT_W-1:0] cfg_wdata,
  input  logic [15:0]         s_tdata,
  input  logic [1:0]          s_tuser,
  input  cmd_t                cmd,
  output stat_t               st,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast,
  output logic [1:0]          m_tuser
);

  localparam int NIW = $clog2(MAX_NODES);
  localparam int SW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int DW  = NIW + 1;
  localparam int AW  = NIW + SW;
  localparam int EW  = NODE_W + CW;

  logic [NODE_W-1:0]   store_mem [2**AW];
  logic [CW-1:0]       cnt_mem   [MAX_NODES];
  logic [EW-1:0]       stack_mem [MAX_NODES];

  logic [NODE_W-1:0]   store_q;
  logic [CW-1:0]       cnt_q;
  logic [EW-1:0]       stack_q;

  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] cnt_vld;
  logic [NCOUNT_W-1:0]  node_count;
  logic [NCOUNT_W-1:0]  scan;
  logic [NODE_W-1:0]    top_node, top_node_next;
  logic [CW-1:0]        top_cur, top_cur_next;
  logic [DW-1:0]        depth, depth_next;
  logic [NODE_W-1:0]    pend;
  logic [NODE_W-1:0]    in_nb;
  op_t                  op;
  status_t              res_status;

  logic [NODE_W-1:0]    out_found;
  logic                 out_last;
  status_t              out_status;

  logic [CW-1:0]        cnt_cur;
  logic [NIW-1:0]       stk_wa, stk_ra;
  logic [EW-1:0]        stk_wd;
  logic                 out_free;
  logic                 child_ok;

  assign cnt_cur  = cnt_vld[top_node[NIW-1:0]] ? cnt_q : '0;
  assign out_free = !m_tvalid || m_tready;
  assign child_ok = ({1'b0, store_q} < node_count) && !visited[store_q[NIW-1:0]];
  assign stk_wa   = depth[NIW-1:0] - 1'b1;
  assign stk_ra   = depth_next[NIW-1:0] - NIW'(2);
  assign stk_wd   = {top_node, top_cur + 1'b1};

  always_comb begin
    top_node_next = top_node;
    top_cur_next  = top_cur;
    depth_next    = depth;
    if (cmd.latch_in) begin
      top_node_next = s_tdata[NODE_W-1:0];
    end
    if (cmd.root_start) begin
      top_node_next = scan[NODE_W-1:0];
      top_cur_next  = '0;
      depth_next    = DW'(1);
    end
    if (cmd.cur_inc) begin
      top_cur_next = top_cur + 1'b1;
    end
    if (cmd.push) begin
      top_node_next = store_q;
      top_cur_next  = '0;
      depth_next    = depth + 1'b1;
    end
    if (cmd.pop) begin
      top_node_next = stack_q[EW-1:CW];
      top_cur_next  = stack_q[CW-1:0];
      depth_next    = depth - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.app_write) begin
      store_mem[{top_node[NIW-1:0], cnt_cur[SW-1:0]}] <= in_nb;
      cnt_mem[top_node[NIW-1:0]] <= cnt_cur + 1'b1;
    end
    store_q <= store_mem[{top_node_next[NIW-1:0], top_cur_next[SW-1:0]}];
    cnt_q   <= cnt_mem[top_node_next[NIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    stack_q <= (cmd.push && stk_wa == stk_ra) ? stk_wd : stack_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    top_node <= top_node_next;
    top_cur  <= top_cur_next;
    if (cmd.latch_in) begin
      in_nb <= s_tdata[2*NODE_W-1:NODE_W];
      op    <= op_t'(s_tuser);
    end
    if (cmd.root_start) begin
      pend <= scan[NODE_W-1:0];
    end else if (cmd.push) begin
      pend <= store_q;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status;
    end
    if (cmd.scan_rst) begin
      scan <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + 1'b1;
    end
    if (cmd.emit_single) begin
      out_found  <= '0;
      out_last   <= 1'b1;
      out_status <= res_status;
    end else if (cmd.emit_pend) begin
      out_found  <= pend;
      out_last   <= cmd.emit_last;
      out_status <= ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited    <= '0;
      cnt_vld    <= '0;
      depth      <= '0;
      node_count <= NCOUNT_W'(MAX_NODES);
      m_tvalid   <= 1'b0;
    end else begin
      depth <= depth_next;
      if (cmd.clr_all || cmd.clr_vis) begin
        visited <= '0;
      end else if (cmd.root_start) begin
        visited[scan[NIW-1:0]] <= 1'b1;
      end else if (cmd.push) begin
        visited[store_q[NIW-1:0]] <= 1'b1;
      end
      if (cmd.clr_all) begin
        cnt_vld <= '0;
      end else if (cmd.app_write) begin
        cnt_vld[top_node[NIW-1:0]] <= 1'b1;
      end
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          node_count <= NCOUNT_W'(1);
        end else if (cfg_wdata > NCOUNT_W'(MAX_NODES)) begin
          node_count <= NCOUNT_W'(MAX_NODES);
        end else begin
          node_count <= cfg_wdata;
        end
      end
      if (cmd.emit_single || cmd.emit_pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    st            = '0;
    st.op         = op;
    st.range_ok   = ({1'b0, top_node} < node_count) && ({1'b0, in_nb} < node_count);
    st.list_full  = cnt_cur >= CW'(MAX_DEGREE);
    st.scan_end   = scan >= node_count;
    st.scan_unvis = !visited[scan[NIW-1:0]];
    st.exhausted  = top_cur >= cnt_cur;
    st.depth_one  = depth == DW'(1);
    st.child_ok   = child_ok;
    st.out_free   = out_free;
  end

  assign m_tdata = {2'b00, out_found};
  assign m_tlast = out_last;
  assign m_tuser = out_status;

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    NCOUNT_W'(depth) <= node_count)
    else $error("walk stack deeper than node count");

  a_push_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> child_ok && out_free)
    else $error("push without a free output or an unvisited child");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status != ST_OK |-> out_found == '0)
    else $error("error word carries a node");

  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_last |-> out_status == ST_OK)
    else $error("non-final word with error status");

endmodule

// ===== sv/connected_component_enumerator.sv =====
// Top level: depth-first connected component enumerator.
// Append and clear words: decode, then emit once the output is free; the next word is taken after the emit.
// Next component: one cycle per node scanned, per neighbor slot examined (a push takes that
// cycle once the output is free) and per pop; the walk waits while the output is held.
// Reset clears visited map, list counts, stack depth and output; node_count returns to MAX_NODES.
module connected_component_enumerator
  import cce_pkg::*;
#(
  parameter int MAX_NODES  = 64,
  parameter int MAX_DEGREE = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [NCOUNT_W-1:0] cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // node_index[5:0], neighbor_index[11:6]
  input  logic [1:0]          s_tuser,   // operation[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // found_node[5:0]
  output logic                m_tlast,
  output logic [1:0]          m_tuser    // status[1:0]
);

  cmd_t  cmd;
  stat_t st;

  cce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  cce_dp #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== sim/tb_connected_component_enumerator.sv =====
`timescale 1ns / 100ps
// Testbench of the connected component enumerator: directed and random graphs, checked word by word.
module tb_connected_component_enumerator
  import cce_pkg::*;
();

  localparam int NODES        = 64;
  localparam int DEGREE       = 16;
  localparam int RANDOM_WORDS = 280;
  localparam int QUIET_LIMIT  = 20000;
  localparam int SETTLE       = 8;

  typedef struct {
    logic [5:0] node;
    logic       last;
    status_t    status;
  } result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [NCOUNT_W-1:0] cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata   = '0;   // node_index[5:0], neighbor_index[11:6]
  logic [1:0]          s_tuser   = '0;   // operation[1:0]
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [7:0]          m_tdata;          // found_node[5:0]
  logic                m_tlast;
  logic [1:0]          m_tuser;          // status[1:0]

  connected_component_enumerator #(
    .MAX_NODES (NODES),
    .MAX_DEGREE(DEGREE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  logic [5:0] adj [NODES][DEGREE];
  int         adj_len [NODES];
  bit         seen [NODES];
  int         cursor [NODES];
  logic [5:0] dfs_stack [NODES];
  int         dfs_depth;
  int         live_nodes;
  status_t    last_status;
  result_t    pending [$];

  int mismatches        = 0;
  int words_sent        = 0;
  int results_checked   = 0;
  int components_walked = 0;
  int cfg_writes        = 0;
  int quiet             = 0;
  int rx_hold           = 0;
  int rx_gap            = 0;
  bit tx_idle_en        = 1'b1;
  bit rx_idle_en        = 1'b1;

  function automatic void reset_predictor();
    foreach (adj_len[i]) adj_len[i] = 0;
    foreach (seen[i]) seen[i] = 1'b0;
    dfs_depth  = 0;
    live_nodes = NODES;
  endfunction

  function automatic void predict_word(op_t op, logic [5:0] node, logic [5:0] nb);
    result_t run [$];
    result_t r;
    int      root;
    int      parent;
    int      c;
    bit      found;
    r.node   = '0;
    r.last   = 1'b1;
    r.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (node >= live_nodes || nb >= live_nodes) begin
          r.status = ST_RANGE;
        end else if (adj_len[node] >= DEGREE) begin
          r.status = ST_FULL;
        end else begin
          adj[node][adj_len[node]] = nb;
          adj_len[node]++;
        end
        run.insert(run.size(), r);
      end
      OP_CLR_ALL: begin
        foreach (adj_len[i]) adj_len[i] = 0;
        foreach (seen[i]) seen[i] = 1'b0;
        dfs_depth = 0;
        run.insert(run.size(), r);
      end
      OP_CLR_VIS: begin
        foreach (seen[i]) seen[i] = 1'b0;
        dfs_depth = 0;
        run.insert(run.size(), r);
      end
      default: begin
        root = live_nodes;
        for (int v = 0; v < live_nodes; v++) begin
          if (!seen[v]) begin
            root = v;
            break;
          end
        end
        if (root >= live_nodes) begin
          r.status = ST_NONE;
          run.insert(run.size(), r);
        end else begin
          components_walked++;
          r.last = 1'b0;
          seen[root]   = 1'b1;
          cursor[root] = 0;
          dfs_stack[0] = 6'(root);
          dfs_depth    = 1;
          r.node = 6'(root);
          run.insert(run.size(), r);
          while (dfs_depth > 0) begin
            parent = dfs_stack[dfs_depth - 1];
            found  = 1'b0;
            c      = 0;
            while (cursor[parent] < adj_len[parent] && !found) begin
              c = adj[parent][cursor[parent]];
              cursor[parent]++;
              if (c < live_nodes && !seen[c]) found = 1'b1;
            end
            if (found) begin
              seen[c]   = 1'b1;
              cursor[c] = 0;
              r.node    = 6'(c);
              run.insert(run.size(), r);
              dfs_stack[dfs_depth] = 6'(c);
              dfs_depth++;
            end else begin
              dfs_depth--;
            end
          end
          run[run.size() - 1].last = 1'b1;
        end
      end
    endcase
    last_status = run[run.size() - 1].status;
    foreach (run[i]) pending.insert(pending.size(), run[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [5:0] rand6();
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic send_word(op_t op, logic [5:0] node, logic [5:0] nb);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, nb, node};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_word(op, node, nb);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_node_count(logic [6:0] value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (value == 0) live_nodes = 1;
    else if (value > NODES) live_nodes = NODES;
    else live_nodes = value;
    cfg_writes++;
  endtask

  task automatic enumerate_all();
    do begin
      send_word(OP_NEXT, rand6(), rand6());
    end while (last_status != ST_NONE);
  endtask

  task automatic test_directed();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_word(OP_NEXT, 6'd63, 6'd63);
    send_word(OP_CLR_ALL, 6'd0, 6'd0);
    send_word(OP_APPEND, 6'd0, 6'd63);
    for (int j = 0; j < DEGREE; j++) send_word(OP_APPEND, 6'd5, 6'(j + 6));
    send_word(OP_APPEND, 6'd5, 6'd1);
    send_word(OP_NEXT, 6'd0, 6'd0);
    send_word(OP_NEXT, 6'd0, 6'd0);
    write_node_count(7'd0);
    send_word(OP_APPEND, 6'd0, 6'd1);
    send_word(OP_NEXT, 6'd0, 6'd0);
    send_word(OP_CLR_VIS, 6'd63, 6'd63);
    send_word(OP_NEXT, 6'd0, 6'd0);
    send_word(OP_NEXT, 6'd0, 6'd0);
    write_node_count(7'd127);
  endtask

  task automatic test_random_graphs();
    int start;
    int n;
    int edges;
    int a;
    int b;
    int kind;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        // keep the graph: neighbors at or above the new count go stale
        write_node_count(7'($urandom_range(1, NODES)));
      end else begin
        if (kind < 25) begin
          case ($urandom_range(0, 3))
            0: write_node_count(7'd0);
            1: write_node_count(7'd1);
            2: write_node_count(7'd64);
            default: write_node_count(7'd127);
          endcase
        end else if (kind < 75) begin
          write_node_count(7'($urandom_range(2, 12)));
        end else begin
          write_node_count(7'($urandom_range(13, NODES)));
        end
        send_word(OP_CLR_ALL, rand6(), rand6());
        n = live_nodes;
        edges = $urandom_range(0, (n < 20) ? 2 * n : 40);
        repeat (edges) begin
          a = $urandom_range(0, n - 1);
          b = $urandom_range(0, n - 1);
          kind = $urandom_range(0, 99);
          if (kind < 60) begin
            send_word(OP_APPEND, 6'(a), 6'(b));
            send_word(OP_APPEND, 6'(b), 6'(a));
          end else if (kind < 85) begin
            send_word(OP_APPEND, 6'(a), 6'(b));
          end else if (kind < 95) begin
            send_word(OP_APPEND, rand6(), rand6());
          end else begin
            send_word(OP_CLR_VIS, rand6(), rand6());
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          a = $urandom_range(0, n - 1);
          repeat (DEGREE + 2) send_word(OP_APPEND, 6'(a), 6'($urandom_range(0, n - 1)));
        end
      end
      enumerate_all();
      if ($urandom_range(0, 1) == 1) begin
        send_word(OP_CLR_VIS, rand6(), rand6());
        repeat ($urandom_range(1, 3)) send_word(OP_NEXT, rand6(), rand6());
      end
    end
  endtask

  task automatic test_output_stall();
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
    write_node_count(7'd64);
    send_word(OP_CLR_ALL, 6'd0, 6'd0);
    for (int i = 0; i < 40; i++) send_word(OP_APPEND, 6'(i), 6'(i + 1));
    drain();
    // hold the output while requests keep coming
    tx_idle_en = 1'b0;
    rx_hold    = 400;
    repeat (6) send_word(OP_NEXT, rand6(), rand6());
    drain();
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else if (rx_gap > 0) begin
      m_tready <= 1'b0;
      rx_gap--;
    end else begin
      m_tready <= 1'b1;
      if (rx_idle_en && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
    end
  end

  always @(posedge clk) begin : check_output
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected word data=%0h last=%0b status=%0d",
                                  m_tdata, m_tlast, m_tuser));
      end else begin
        want = pending.pop_front();
        if (m_tdata !== {2'b00, want.node})
          report_mismatch($sformatf("found_node %0d, want %0d", m_tdata, want.node));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
        if (m_tuser !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Timeout after %0d quiet cycles", quiet);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_graphs();
    test_output_stall();
    drain();
    repeat (20) @(posedge clk);
    if (pending.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", pending.size()));
    $display("Sent %0d words, checked %0d result words, walked %0d components.",
             words_sent, results_checked, components_walked);
    $display("Wrote node_count %0d times, with idle gaps and a long output stall.", cfg_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
